// ----- rtl/core/lgs_pkg.sv -----
// Shared constants, codes and arithmetic helpers for the linear gradient shader.
`timescale 1ns / 1ps

package lgs_pkg;

	// Table and number formats.
	localparam int MAX_STOPS  = 16;
	localparam int STOP_AW    = $clog2(MAX_STOPS);
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int CHAN_W     = 16;
	localparam int STOP_W     = 4 * CHAN_W;
	localparam int COEF_W     = 32;
	localparam int MAP_FRAC   = 17;
	localparam int T_SHIFT    = MAP_FRAC - FRAC_BITS;

	// Mapping datapath widths: coefficient times (2*coord+1), then a sum of three terms.
	localparam int MAP_PROD_W = COEF_W + COORD_BITS + 2;
	localparam int MAP_SUM_W  = MAP_PROD_W + 2;
	localparam int T_W        = MAP_SUM_W - T_SHIFT;
	localparam int TT_W       = FRAC_BITS + 1;
	localparam int SCALED_W   = TT_W + STOP_AW;

	localparam logic [TT_W-1:0] T_ONE = TT_W'(1) << FRAC_BITS;

	// Configuration port.
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_X_SCALE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_Y_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_OFFSET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_MODE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 3'd4;

	// Tile modes; the unused code behaves as clamp.
	localparam logic [1:0] TILE_CLAMP  = 2'd0;
	localparam logic [1:0] TILE_REPEAT = 2'd1;
	localparam logic [1:0] TILE_MIRROR = 2'd2;

	// Input word kinds.
	localparam logic KIND_STOP  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// Fold the gradient parameter into [0, 1] by the tile mode.
	function automatic logic [TT_W-1:0] tile_fold(input logic signed [T_W-1:0] t,
			input logic [1:0] mode);
		logic [TT_W:0]   u;
		logic [TT_W-1:0] r;
		u = {1'b0, t[TT_W-1:0]};
		case (mode)
			TILE_REPEAT: begin
				r = {1'b0, t[FRAC_BITS-1:0]};
			end
			TILE_MIRROR: begin
				if (u > {1'b0, T_ONE}) begin
					u = ({1'b0, T_ONE} << 1) - u;
				end
				r = u[TT_W-1:0];
			end
			default: begin
				if (t < 0) begin
					r = '0;
				end else if (t > $signed(T_W'(T_ONE))) begin
					r = T_ONE;
				end else begin
					r = t[TT_W-1:0];
				end
			end
		endcase
		return r;
	endfunction

	// Weighted blend of two stop channels, rounded to nearest.
	function automatic logic [CHAN_W-1:0] lerp_chan(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b, input logic [FRAC_BITS-1:0] w);
		logic [CHAN_W+TT_W:0] s;
		s = (CHAN_W + TT_W + 1)'(a) * (CHAN_W + TT_W + 1)'(T_ONE - TT_W'(w))
			+ (CHAN_W + TT_W + 1)'(b) * (CHAN_W + TT_W + 1)'(w)
			+ (CHAN_W + TT_W + 1)'(T_ONE >> 1);
		return s[FRAC_BITS+CHAN_W-1:FRAC_BITS];
	endfunction

endpackage

// ----- rtl/core/lgs_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module lgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports; data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ----- rtl/core/linear_gradient_shader_top.sv -----
// Top level of the linear gradient shader: config registers and the shading pipeline.
`timescale 1ns / 1ps

// Accepts one word per clock while in_stall is low and returns one shaded pixel
// per pixel word; stop-write words return nothing. The pipeline is seven register
// stages: two for the mapping multiply and sum, one for the tile fold, one for the
// stop-table read, one for the channel blend and two for the premultiply and the
// 8-bit rounding. The color-stop table is a 16 x 64 RAM with two read ports; a
// stop write lands in it in order with the pixel words around it, so a pixel
// accepted after a stop write sees that stop. The table has no reset and no
// clearing pass: every stop a pixel uses must be written first. Each stage moves
// on when the stage after it is empty or moving, so a stalled output word does not
// keep bubbles from filling up.
module linear_gradient_shader_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0]            cfg_data,
	// Input channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic [3:0]                           stop_index,
	input  logic [15:0]                          stop_red,
	input  logic [15:0]                          stop_green,
	input  logic [15:0]                          stop_blue,
	input  logic [15:0]                          stop_alpha,
	input  logic [lgs_pkg::COORD_BITS-1:0]       pixel_x,
	input  logic [lgs_pkg::COORD_BITS-1:0]       pixel_y,
	input  logic                                 last_in_span,
	// Output channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           out_alpha,
	output logic [7:0]                           out_red,
	output logic [7:0]                           out_green,
	output logic [7:0]                           out_blue,
	output logic                                 span_end
);

	localparam int NSTG = 7;

	// Configuration registers.
	logic signed [lgs_pkg::COEF_W-1:0] map_x_scale_q;
	logic signed [lgs_pkg::COEF_W-1:0] map_y_scale_q;
	logic signed [lgs_pkg::COEF_W-1:0] map_offset_q;
	logic [1:0]                        tile_mode_q;
	logic [4:0]                        stop_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_x_scale_q <= lgs_pkg::COEF_W'(65536);
			map_y_scale_q <= '0;
			map_offset_q  <= '0;
			tile_mode_q   <= lgs_pkg::TILE_CLAMP;
			stop_count_q  <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				lgs_pkg::REG_MAP_X_SCALE: map_x_scale_q <= cfg_data;
				lgs_pkg::REG_MAP_Y_SCALE: map_y_scale_q <= cfg_data;
				lgs_pkg::REG_MAP_OFFSET:  map_offset_q  <= cfg_data;
				lgs_pkg::REG_TILE_MODE:   tile_mode_q   <= cfg_data[1:0];
				lgs_pkg::REG_STOP_COUNT:  stop_count_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Highest usable stop index: stop count limited to 1..MAX_STOPS, minus one.
	logic [lgs_pkg::STOP_AW-1:0] last_stop;
	always_comb begin
		if (stop_count_q == 5'd0) begin
			last_stop = '0;
		end else if (6'(stop_count_q) > 6'(lgs_pkg::MAX_STOPS)) begin
			last_stop = lgs_pkg::STOP_AW'(lgs_pkg::MAX_STOPS - 1);
		end else begin
			last_stop = lgs_pkg::STOP_AW'(stop_count_q - 5'd1);
		end
	end

	// Stage handshake: a stage loads when it is empty or its contents move on.
	logic [NSTG:1]   vld;
	logic [NSTG+1:1] rdy;
	always_comb begin
		rdy[NSTG+1] = !out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !vld[k] || rdy[k+1];
		end
	end
	assign in_stall = !rdy[1];

	// Stage 1: coefficient products with the doubled pixel center.
	logic                                    kind_s1;
	logic                                    last_s1;
	logic [lgs_pkg::STOP_AW-1:0]             sidx_s1;
	logic [lgs_pkg::STOP_W-1:0]              sdata_s1;
	logic signed [lgs_pkg::MAP_PROD_W-1:0]   prodx_s1;
	logic signed [lgs_pkg::MAP_PROD_W-1:0]   prody_s1;

	always_ff @(posedge clk) begin
		if (rdy[1] && in_valid) begin
			kind_s1  <= kind;
			last_s1  <= last_in_span;
			sidx_s1  <= stop_index[lgs_pkg::STOP_AW-1:0];
			sdata_s1 <= {stop_alpha, stop_blue, stop_green, stop_red};
			prodx_s1 <= map_x_scale_q * $signed({1'b0, pixel_x, 1'b1});
			prody_s1 <= map_y_scale_q * $signed({1'b0, pixel_y, 1'b1});
		end
	end

	// Stage 2: sum in Q.17, floored to the weight precision.
	logic signed [lgs_pkg::MAP_SUM_W-1:0] map_sum;
	assign map_sum = lgs_pkg::MAP_SUM_W'(prodx_s1) + lgs_pkg::MAP_SUM_W'(prody_s1)
		+ (lgs_pkg::MAP_SUM_W'(map_offset_q) <<< 1);

	logic                             kind_s2;
	logic                             last_s2;
	logic [lgs_pkg::STOP_AW-1:0]      sidx_s2;
	logic [lgs_pkg::STOP_W-1:0]       sdata_s2;
	logic signed [lgs_pkg::T_W-1:0]   t_s2;

	always_ff @(posedge clk) begin
		if (rdy[2] && vld[1]) begin
			kind_s2  <= kind_s1;
			last_s2  <= last_s1;
			sidx_s2  <= sidx_s1;
			sdata_s2 <= sdata_s1;
			t_s2     <= lgs_pkg::T_W'(map_sum >>> lgs_pkg::T_SHIFT);
		end
	end

	// Stage 3: tile fold into [0, 1].
	logic                         kind_s3;
	logic                         last_s3;
	logic [lgs_pkg::STOP_AW-1:0]  sidx_s3;
	logic [lgs_pkg::STOP_W-1:0]   sdata_s3;
	logic [lgs_pkg::TT_W-1:0]     tt_s3;

	always_ff @(posedge clk) begin
		if (rdy[3] && vld[2]) begin
			kind_s3  <= kind_s2;
			last_s3  <= last_s2;
			sidx_s3  <= sidx_s2;
			sdata_s3 <= sdata_s2;
			tt_s3    <= lgs_pkg::tile_fold(t_s2, tile_mode_q);
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1]) vld[1] <= in_valid;
			if (rdy[2]) vld[2] <= vld[1];
			if (rdy[3]) vld[3] <= vld[2];
			// Stop writes leave the pipeline once they reach the table.
			if (rdy[4]) vld[4] <= vld[3] && kind_s3 == lgs_pkg::KIND_PIXEL;
			if (rdy[5]) vld[5] <= vld[4];
			if (rdy[6]) vld[6] <= vld[5];
			if (rdy[7]) vld[7] <= vld[6];
		end
	end

	// Stop index and weight from t scaled by the stop span.
	logic [lgs_pkg::SCALED_W-1:0] scaled;
	logic [lgs_pkg::STOP_AW:0]    idx_lo;
	logic [lgs_pkg::STOP_AW:0]    idx_hi;
	always_comb begin
		scaled = lgs_pkg::SCALED_W'(tt_s3) * lgs_pkg::SCALED_W'(last_stop);
		idx_lo = scaled[lgs_pkg::SCALED_W-1:lgs_pkg::FRAC_BITS];
		if (idx_lo > {1'b0, last_stop}) begin
			idx_lo = {1'b0, last_stop};
		end
		idx_hi = idx_lo + 1'b1;
		if (idx_hi > {1'b0, last_stop}) begin
			idx_hi = {1'b0, last_stop};
		end
	end

	// Stage 4: stop table; writes and reads happen in word order at this step.
	logic                            tbl_we;
	logic                            tbl_re;
	logic [lgs_pkg::STOP_W-1:0]      stop_lo;
	logic [lgs_pkg::STOP_W-1:0]      stop_hi;
	logic [lgs_pkg::FRAC_BITS-1:0]   w_s4;
	logic                            last_s4;

	assign tbl_we = rdy[4] && vld[3] && kind_s3 == lgs_pkg::KIND_STOP;
	assign tbl_re = rdy[4] && vld[3] && kind_s3 == lgs_pkg::KIND_PIXEL;

	lgs_ram #(
		.WIDTH (lgs_pkg::STOP_W),
		.DEPTH (lgs_pkg::MAX_STOPS)
	) u_stops (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (sidx_s3),
		.wdata   (sdata_s3),
		.re      (tbl_re),
		.raddr_a (idx_lo[lgs_pkg::STOP_AW-1:0]),
		.raddr_b (idx_hi[lgs_pkg::STOP_AW-1:0]),
		.rdata_a (stop_lo),
		.rdata_b (stop_hi)
	);

	always_ff @(posedge clk) begin
		if (tbl_re) begin
			w_s4    <= scaled[lgs_pkg::FRAC_BITS-1:0];
			last_s4 <= last_s3;
		end
	end

	// Stage 5: blend the two neighboring stops per channel.
	logic [lgs_pkg::CHAN_W-1:0] red_s5, green_s5, blue_s5, alpha_s5;
	logic                       last_s5;

	always_ff @(posedge clk) begin
		if (rdy[5] && vld[4]) begin
			red_s5   <= lgs_pkg::lerp_chan(stop_lo[15:0],  stop_hi[15:0],  w_s4);
			green_s5 <= lgs_pkg::lerp_chan(stop_lo[31:16], stop_hi[31:16], w_s4);
			blue_s5  <= lgs_pkg::lerp_chan(stop_lo[47:32], stop_hi[47:32], w_s4);
			alpha_s5 <= lgs_pkg::lerp_chan(stop_lo[63:48], stop_hi[63:48], w_s4);
			last_s5  <= last_s4;
		end
	end

	// Stage 6: 8-bit alpha and color-times-alpha products.
	logic [23:0] alpha_x255;
	assign alpha_x255 = 24'(alpha_s5) * 24'd255 + 24'h8000;

	logic [7:0]  alpha_s6;
	logic [31:0] red_s6, green_s6, blue_s6;
	logic        last_s6;

	always_ff @(posedge clk) begin
		if (rdy[6] && vld[5]) begin
			alpha_s6 <= alpha_x255[23:16];
			red_s6   <= 32'(red_s5) * 32'(alpha_s5);
			green_s6 <= 32'(green_s5) * 32'(alpha_s5);
			blue_s6  <= 32'(blue_s5) * 32'(alpha_s5);
			last_s6  <= last_s5;
		end
	end

	// Stage 7: premultiplied 8-bit channels, rounded; this is the output word.
	logic [39:0] red_x255, green_x255, blue_x255;
	assign red_x255   = 40'(red_s6) * 40'd255 + 40'h8000_0000;
	assign green_x255 = 40'(green_s6) * 40'd255 + 40'h8000_0000;
	assign blue_x255  = 40'(blue_s6) * 40'd255 + 40'h8000_0000;

	logic [7:0] alpha_s7, red_s7, green_s7, blue_s7;
	logic       last_s7;

	always_ff @(posedge clk) begin
		if (rdy[7] && vld[6]) begin
			alpha_s7 <= alpha_s6;
			red_s7   <= red_x255[39:32];
			green_s7 <= green_x255[39:32];
			blue_s7  <= blue_x255[39:32];
			last_s7  <= last_s6;
		end
	end

	assign out_valid = vld[NSTG];
	assign out_alpha = alpha_s7;
	assign out_red   = red_s7;
	assign out_green = green_s7;
	assign out_blue  = blue_s7;
	assign span_end  = last_s7;

endmodule
